// File: rtl/spb_pkg.sv
// ----------------------------------------------------------------------------
// spb_pkg
// Shared types and constants of the sphere particle bounce unit.
// ----------------------------------------------------------------------------
package spb_pkg;

    // Quotient bits produced by the pipelined divider.
    // The correction term is below 2^33 whenever the particle hits.
    localparam int DIV_STEPS = 33;

    // Width of the divider remainder and of the squared offset length.
    localparam int REM_W = 64;

    // Per-item values that ride along with the arithmetic.
    typedef struct packed {
        logic            hit;
        logic            pass;
        logic [2:0]      flip;
        logic [2:0][31:0] vel;
    } side_t;

    // One lane of the divider: remainder, plus the unused dividend bits
    // on top and the quotient bits collected so far below them.
    typedef struct packed {
        logic [REM_W-1:0]     rem;
        logic [DIV_STEPS-1:0] low;
    } div_lane_t;

    // Payload of a divider stage.
    typedef struct packed {
        logic [REM_W-1:0]  dd;
        div_lane_t [2:0]   lane;
        side_t             side;
    } div_t;

    // Finished result.
    typedef struct packed {
        logic             hit;
        logic [2:0][31:0] vel;
    } result_t;

endpackage

// File: rtl/sphere_particle_bounce_unit.sv
// Pipeline: an accepted input transaction passes through 6 front stages,
// 33 divider stages, 1 rounding stage and 1 output register to out_valid.
// Throughput: one transaction per cycle; the 33-step divider is fully pipelined.
// The whole pipeline stalls only while the output skid register is occupied.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers keep
// whatever they hold.
// ----------------------------------------------------------------------------
// sphere_particle_bounce_unit
// Sphere and point collision test with reflection of the particle velocity.
// ----------------------------------------------------------------------------
module sphere_particle_bounce_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic [30:0]        radius,
    input  logic signed [31:0] particle_x,
    input  logic signed [31:0] particle_y,
    input  logic signed [31:0] particle_z,
    input  logic signed [31:0] velocity_x,
    input  logic signed [31:0] velocity_y,
    input  logic signed [31:0] velocity_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic signed [31:0] new_velocity_x,
    output logic signed [31:0] new_velocity_y,
    output logic signed [31:0] new_velocity_z
);

    logic             en;
    logic             skid_valid_reg;
    logic             out_valid_reg;
    spb_pkg::result_t out_reg;
    spb_pkg::result_t skid_reg;

    // The pipeline advances whenever the skid register is free.
    assign en       = !skid_valid_reg;
    assign in_ready = en;

    // Front end.
    logic          front_valid;
    spb_pkg::div_t front_data;

    spb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .center    ({center_z, center_y, center_x}),
        .particle  ({particle_z, particle_y, particle_x}),
        .velocity  ({velocity_z, velocity_y, velocity_x}),
        .radius    (radius),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    // Divider chain, one quotient bit per stage.
    logic          div_valid [spb_pkg::DIV_STEPS+1];
    spb_pkg::div_t div_data  [spb_pkg::DIV_STEPS+1];

    assign div_valid[0] = front_valid;
    assign div_data[0]  = front_data;

    for (genvar g = 0; g < spb_pkg::DIV_STEPS; g++)
    begin : g_div
        spb_div_stage u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (div_valid[g]),
            .in_data   (div_data[g]),
            .out_valid (div_valid[g+1]),
            .out_data  (div_data[g+1])
        );
    end

    // Rounding and saturation.
    logic             back_valid;
    spb_pkg::result_t back_data;

    spb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid[spb_pkg::DIV_STEPS]),
        .in_data   (div_data[spb_pkg::DIV_STEPS]),
        .out_valid (back_valid),
        .out_data  (back_data)
    );

    // Output register with a skid register behind it.
    logic take;
    assign take = en && back_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && out_ready)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= take;
        end
        else if (!out_valid_reg)
            out_valid_reg <= take;
        else if (take)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && out_ready)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (take)
                out_reg <= back_data;
        end
        else if (!out_valid_reg)
        begin
            if (take)
                out_reg <= back_data;
        end
        else if (take)
            skid_reg <= back_data;
    end

    assign out_valid      = out_valid_reg;
    assign hit            = out_reg.hit;
    assign new_velocity_x = out_reg.vel[0];
    assign new_velocity_y = out_reg.vel[1];
    assign new_velocity_z = out_reg.vel[2];

    // The skid register only holds a transaction behind a waiting output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register valid with empty output register");

    // A waiting skid transaction is kept until the output drains.
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !out_ready |=> skid_valid_reg && $stable(skid_reg))
        else $error("skid transaction lost while output stalled");

    // The skid drains into the output register once the output is taken.
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_ready |=> out_valid_reg && !skid_valid_reg
                                        && out_reg == $past(skid_reg))
        else $error("skid transaction not moved to output");

    // An output that is refused stays valid.
    a_out_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("output transaction dropped");

endmodule

// File: rtl/spb_front.sv
// ----------------------------------------------------------------------------
// spb_front
// Six register stages: offset, products, sums, hit test, and the wide
// numerator 2*|v.d|*|d_i| for each axis, set up as divider lanes.
// ----------------------------------------------------------------------------
module spb_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2:0][31:0]      center,
    input  logic [2:0][31:0]      particle,
    input  logic [2:0][31:0]      velocity,
    input  logic [30:0]           radius,
    output logic                  out_valid,
    output spb_pkg::div_t         out_data
);

    // Valid bits travel with the stages.
    logic [5:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[4:0], in_valid};
    end

    assign out_valid = valid_reg[5];

    // Stage 1: offset d = center - particle, as magnitude and sign.
    logic [2:0][32:0] s1_diff;
    logic [2:0][32:0] s1_ndiff;
    logic [2:0][31:0] s1_dmag_reg;
    logic [2:0]       s1_dneg_reg;
    logic [2:0][31:0] s1_vel_reg;
    logic [30:0]      s1_r_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_diff[i]  = {center[i][31], center[i]} - {particle[i][31], particle[i]};
            s1_ndiff[i] = 33'd0 - s1_diff[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_dmag_reg[i] <= s1_diff[i][32] ? s1_ndiff[i][31:0] : s1_diff[i][31:0];
                s1_dneg_reg[i] <= s1_diff[i][32];
            end
            s1_vel_reg <= velocity;
            s1_r_reg   <= radius;
        end
    end

    // Stage 2: squares, radius squared and the terms of v.d.
    logic [2:0][31:0] s2_vmag;
    logic [2:0]       s2_inbox;
    logic [2:0][61:0] s2_sq_reg;
    logic [2:0][62:0] s2_pv_reg;
    logic [2:0]       s2_sgn_reg;
    logic [61:0]      s2_rr_reg;
    logic             s2_box_reg;
    logic [2:0][30:0] s2_dmag_reg;
    logic [2:0]       s2_dneg_reg;
    logic [2:0][31:0] s2_vel_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_vmag[i]  = s1_vel_reg[i][31] ? (32'd0 - s1_vel_reg[i]) : s1_vel_reg[i];
            s2_inbox[i] = (s1_dmag_reg[i] <= {1'b0, s1_r_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s2_sq_reg[i]   <= 62'(s1_dmag_reg[i][30:0]) * 62'(s1_dmag_reg[i][30:0]);
                s2_pv_reg[i]   <= 63'(s2_vmag[i]) * 63'(s1_dmag_reg[i][30:0]);
                s2_sgn_reg[i]  <= s1_vel_reg[i][31] ^ s1_dneg_reg[i];
                s2_dmag_reg[i] <= s1_dmag_reg[i][30:0];
            end
            s2_rr_reg   <= 62'(s1_r_reg) * 62'(s1_r_reg);
            s2_box_reg  <= &s2_inbox;
            s2_dneg_reg <= s1_dneg_reg;
            s2_vel_reg  <= s1_vel_reg;
        end
    end

    // Stage 3: |d|^2 and the signed dot product.
    logic signed [2:0][65:0] s3_term;
    logic [63:0]             s3_dd_reg;
    logic signed [65:0]      s3_dot_reg;
    logic [61:0]             s3_rr_reg;
    logic                    s3_box_reg;
    logic [2:0][30:0]        s3_dmag_reg;
    logic [2:0]              s3_dneg_reg;
    logic [2:0][31:0]        s3_vel_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s3_term[i] = s2_sgn_reg[i] ? (66'sd0 - 66'(s2_pv_reg[i])) : 66'(s2_pv_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_dd_reg   <= 64'(s2_sq_reg[0]) + 64'(s2_sq_reg[1]) + 64'(s2_sq_reg[2]);
            s3_dot_reg  <= s3_term[0] + s3_term[1] + s3_term[2];
            s3_rr_reg   <= s2_rr_reg;
            s3_box_reg  <= s2_box_reg;
            s3_dmag_reg <= s2_dmag_reg;
            s3_dneg_reg <= s2_dneg_reg;
            s3_vel_reg  <= s2_vel_reg;
        end
    end

    // Stage 4: final hit test and magnitude of the dot product.
    logic               s4_hit;
    logic [65:0]        s4_ndot;
    logic [63:0]        s4_dd_reg;
    logic [63:0]        s4_dotmag_reg;
    logic               s4_dotneg_reg;
    logic               s4_hit_reg;
    logic               s4_pass_reg;
    logic [2:0][30:0]   s4_dmag_reg;
    logic [2:0]         s4_dneg_reg;
    logic [2:0][31:0]   s4_vel_reg;

    assign s4_hit  = s3_box_reg && (s3_dd_reg <= {2'b00, s3_rr_reg});
    assign s4_ndot = 66'd0 - s3_dot_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_dd_reg     <= s3_dd_reg;
            s4_dotmag_reg <= s3_dot_reg[65] ? s4_ndot[63:0] : s3_dot_reg[63:0];
            s4_dotneg_reg <= s3_dot_reg[65];
            s4_hit_reg    <= s4_hit;
            s4_pass_reg   <= !s4_hit || (s3_dd_reg == 64'd0);
            s4_dmag_reg   <= s3_dmag_reg;
            s4_dneg_reg   <= s3_dneg_reg;
            s4_vel_reg    <= s3_vel_reg;
        end
    end

    // Stage 5: partial products of |v.d| * |d_i|, split at bit 32.
    logic [2:0][62:0]   s5_lo_reg;
    logic [2:0][62:0]   s5_hi_reg;
    logic [63:0]        s5_dd_reg;
    spb_pkg::side_t     s5_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s5_lo_reg[i] <= 63'(s4_dotmag_reg[31:0]) * 63'(s4_dmag_reg[i]);
                s5_hi_reg[i] <= 63'(s4_dotmag_reg[63:32]) * 63'(s4_dmag_reg[i]);
                s5_side_reg.flip[i] <= s4_dotneg_reg ^ s4_dneg_reg[i];
            end
            s5_dd_reg        <= s4_dd_reg;
            s5_side_reg.hit  <= s4_hit_reg;
            s5_side_reg.pass <= s4_pass_reg;
            s5_side_reg.vel  <= s4_vel_reg;
        end
    end

    // Stage 6: join the partial products and double the numerator.
    logic [2:0][95:0] s6_prod;
    spb_pkg::div_t    s6_data_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s6_prod[i] = {1'b0, s5_hi_reg[i], 32'd0} + 96'(s5_lo_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s6_data_reg.lane[i].rem <= s6_prod[i][95:32];
                s6_data_reg.lane[i].low <= {s6_prod[i][31:0], 1'b0};
            end
            s6_data_reg.dd   <= s5_dd_reg;
            s6_data_reg.side <= s5_side_reg;
        end
    end

    assign out_data = s6_data_reg;

endmodule

// File: rtl/spb_div_stage.sv
// ----------------------------------------------------------------------------
// spb_div_stage
// One restoring division step for all three lanes, with its register.
// ----------------------------------------------------------------------------
module spb_div_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  spb_pkg::div_t   in_data,
    output logic            out_valid,
    output spb_pkg::div_t   out_data
);

    logic          valid_reg;
    spb_pkg::div_t data_reg;
    spb_pkg::div_t data_next;

    // Shift in the next dividend bit and subtract the divisor if it fits.
    always_comb
    begin
        logic [spb_pkg::REM_W:0] trial;
        logic [spb_pkg::REM_W:0] diff;
        logic                    fits;
        data_next = in_data;
        for (int i = 0; i < 3; i++)
        begin
            trial = {in_data.lane[i].rem, in_data.lane[i].low[spb_pkg::DIV_STEPS-1]};
            diff  = trial - {1'b0, in_data.dd};
            fits  = (trial >= {1'b0, in_data.dd});
            data_next.lane[i].rem = fits ? diff[spb_pkg::REM_W-1:0]
                                         : trial[spb_pkg::REM_W-1:0];
            data_next.lane[i].low = {in_data.lane[i].low[spb_pkg::DIV_STEPS-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/spb_back.sv
// ----------------------------------------------------------------------------
// spb_back
// Rounds the quotients to nearest with ties away from zero, then applies
// the correction to the velocity and saturates to the 32-bit range; a pass item keeps its velocity.
// ----------------------------------------------------------------------------
module spb_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  spb_pkg::div_t     in_data,
    output logic              out_valid,
    output spb_pkg::result_t  out_data
);

    logic                                 valid_reg;
    logic [2:0][spb_pkg::DIV_STEPS:0]     q_reg;
    spb_pkg::side_t                       side_reg;

    // Round: add one when twice the remainder reaches the divisor.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                q_reg[i] <= {1'b0, in_data.lane[i].low}
                          + (spb_pkg::DIV_STEPS+1)'(({in_data.lane[i].rem, 1'b0}
                                                     >= {1'b0, in_data.dd}));
            side_reg <= in_data.side;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // Apply the correction and saturate.
    always_comb
    begin
        logic signed [spb_pkg::DIV_STEPS+1:0] vext;
        logic signed [spb_pkg::DIV_STEPS+1:0] qext;
        logic signed [spb_pkg::DIV_STEPS+1:0] nv;
        out_data.hit = side_reg.hit;
        for (int i = 0; i < 3; i++)
        begin
            vext = (spb_pkg::DIV_STEPS+2)'(signed'(side_reg.vel[i]));
            qext = {1'b0, q_reg[i]};
            nv   = side_reg.flip[i] ? (vext + qext) : (vext - qext);
            if (side_reg.pass)
                out_data.vel[i] = side_reg.vel[i];
            else if (nv > 35'sd2147483647)
                out_data.vel[i] = 32'h7FFF_FFFF;
            else if (nv < -35'sd2147483648)
                out_data.vel[i] = 32'h8000_0000;
            else
                out_data.vel[i] = nv[31:0];
        end
    end

    assign out_valid = valid_reg;

endmodule
